// ----- rtl/core/wstfu_pkg.sv -----
// Shared types and constants for the WebSocket text frame unmasker.
package wstfu_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 7;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned KEY_W    = 32;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned OUT_W    = 16;

    localparam logic [POS_W-1:0]  POS_LEN     = 8'd1;
    localparam logic [POS_W-1:0]  POS_KEY_END = 8'd5;
    localparam logic [POS_W-1:0]  POS_DATA    = 8'd6;
    localparam logic [POS_W-1:0]  POS_MAX     = 8'd255;
    localparam logic [3:0]        OPC_TEXT    = 4'h1;
    localparam logic [LEN_W-1:0]  LEN_MAX     = 7'd125;

    typedef enum logic [STATUS_W-1:0] {
        ST_PAYLOAD = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_SHORT   = 3'd2,
        ST_BADHDR  = 3'd3,
        ST_TRUNC   = 3'd4
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] payload_byte;
        logic              last_payload;
        logic [LEN_W-1:0]  frame_length;
        t_status           status;
    } t_result;

endpackage

// ----- rtl/core/websocket_text_frame_unmasker.sv -----
// Top level of the WebSocket text frame unmasker with its output register.
//
// The slave channel takes the received frame buffer one byte per transfer,
// with tlast set on the final byte of the buffer. The master channel gives
// at most one result per input byte: an unmasked payload byte, or a single
// status for an empty frame, a short buffer, a bad header or a truncated
// payload. Bytes after the outcome of a frame give no result.
// Each byte is parsed by a single level of logic between the parser state
// and the output register, so a result appears in the cycle after its input
// transfer and the block sustains one byte per cycle while tready is held.
// When the receiver stalls, the output register holds its result and the
// slave channel keeps accepting while the register is empty or being
// drained in the same cycle, so throughput drops only while the receiver
// actually withholds tready.
// Synchronous reset clears the parser state and the output valid flag; the
// next byte is then taken as the first byte of a new buffer.
module websocket_text_frame_unmasker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    input  logic [wstfu_pkg::BYTE_W-1:0]     i_s_axis_tdata,   // [7:0] rx_byte
    input  logic                             i_s_axis_tlast,   // end_of_buffer
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    output logic [wstfu_pkg::OUT_W-1:0]      o_m_axis_tdata,   // [7:0] payload_byte,
                                                               // [14:8] frame_length, [15] zero
    output logic [wstfu_pkg::STATUS_W-1:0]   o_m_axis_tuser,   // [2:0] status
    output logic                             o_m_axis_tlast    // last_payload
);
    import wstfu_pkg::*;

    logic    accept;
    t_result res;
    logic    r_valid, n_valid;
    t_result r_out;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    wstfu_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_eob    (i_s_axis_tlast),
        .o_res    (res)
    );

    always_comb begin
        n_valid = r_valid;
        if (res.valid) begin
            n_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.frame_length, r_out.payload_byte};
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tlast  = r_out.last_payload;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Output valid directly after reset.");

    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> (r_out.status == ST_PAYLOAD))
        else $error("Final payload flag on a status transfer.");

    a_status_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out.status != ST_PAYLOAD) |-> (r_out.payload_byte == '0))
        else $error("Status transfer carries a nonzero payload byte.");

    a_load_then_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |=> o_m_axis_tvalid)
        else $error("Parser result lost before the output register.");

endmodule

// ----- rtl/core/wstfu_parse.sv -----
// Frame parser: header checks, mask key capture and payload unmasking for each byte.
module wstfu_parse (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [wstfu_pkg::BYTE_W-1:0]    i_byte,
    input  logic                            i_eob,
    output wstfu_pkg::t_result              o_res
);
    import wstfu_pkg::*;

    logic [POS_W-1:0] r_pos,      n_pos;
    logic             r_hdr_good, n_hdr_good;
    logic [LEN_W-1:0] r_len,      n_len;
    logic [KEY_W-1:0] r_key,      n_key;
    logic             r_done,     n_done;

    logic [1:0]        key_idx;
    logic [1:0]        mask_idx;
    logic [POS_W-1:0]  data_idx;
    logic [BYTE_W-1:0] key_byte;
    t_result           res;

    assign key_idx  = r_pos[1:0] + 2'd2;
    assign mask_idx = r_pos[1:0] + 2'd2;
    assign data_idx = r_pos - POS_DATA;
    assign key_byte = r_key[{mask_idx, 3'b000} +: BYTE_W];

    always_comb begin
        n_pos      = r_pos;
        n_hdr_good = r_hdr_good;
        n_len      = r_len;
        n_key      = r_key;
        n_done     = r_done;
        res        = '0;
        res.status = ST_PAYLOAD;

        if (!r_done) begin
            if (r_pos == '0) begin
                n_hdr_good = i_byte[7] && (i_byte[3:0] == OPC_TEXT);
            end else if (r_pos == POS_LEN) begin
                n_len = i_byte[LEN_W-1:0];
                if (i_byte[LEN_W-1:0] > LEN_MAX) begin
                    n_hdr_good = 1'b0;
                end
            end else if (r_pos <= POS_KEY_END) begin
                for (int k = 0; k < 4; k++) begin
                    if (key_idx == 2'(k)) begin
                        n_key[k*BYTE_W +: BYTE_W] = i_byte;
                    end
                end
            end

            if (r_pos < POS_KEY_END) begin
                if (i_eob) begin
                    res.valid  = 1'b1;
                    res.status = ST_SHORT;
                    n_done     = 1'b1;
                end
            end else if (r_pos == POS_KEY_END) begin
                if (!r_hdr_good) begin
                    res.valid  = 1'b1;
                    res.status = ST_BADHDR;
                    n_done     = 1'b1;
                end else if (r_len == '0) begin
                    res.valid  = 1'b1;
                    res.status = ST_EMPTY;
                    n_done     = 1'b1;
                end else if (i_eob) begin
                    res.valid        = 1'b1;
                    res.frame_length = r_len;
                    res.status       = ST_TRUNC;
                    n_done           = 1'b1;
                end
            end else if (r_hdr_good && (data_idx < {1'b0, r_len})) begin
                res.valid        = 1'b1;
                res.frame_length = r_len;
                if ((data_idx + 8'd1) == {1'b0, r_len}) begin
                    res.payload_byte = i_byte ^ key_byte;
                    res.last_payload = 1'b1;
                    n_done           = 1'b1;
                end else if (i_eob) begin
                    res.status = ST_TRUNC;
                    n_done     = 1'b1;
                end else begin
                    res.payload_byte = i_byte ^ key_byte;
                end
            end
        end

        if (r_pos != POS_MAX) begin
            n_pos = r_pos + 8'd1;
        end

        if (i_eob) begin
            n_pos      = '0;
            n_hdr_good = 1'b0;
            n_len      = '0;
            n_key      = '0;
            n_done     = 1'b0;
        end

        res.valid = res.valid && i_accept;
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_hdr_good <= 1'b0;
            r_len      <= '0;
            r_key      <= '0;
            r_done     <= 1'b0;
        end else if (i_accept) begin
            r_pos      <= n_pos;
            r_hdr_good <= n_hdr_good;
            r_len      <= n_len;
            r_key      <= n_key;
            r_done     <= n_done;
        end
    end

    a_eob_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_eob) |=> (r_pos == '0 && !r_done))
        else $error("State not cleared after the last byte of a buffer.");

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !o_res.valid)
        else $error("Result produced after the frame outcome was reported.");

    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last_payload) |=> (r_done || r_pos == '0))
        else $error("Frame not closed after its final payload byte.");

endmodule
